// ===== rtl/ribbon_vertex_expander_unit_assert.svh =====
// Assertion macros used by the ribbon vertex expander back end.
`ifndef RIBBON_VERTEX_EXPANDER_UNIT_ASSERT_SVH
`define RIBBON_VERTEX_EXPANDER_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define RVE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define RVE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rve_pkg.sv =====
// Shared types and constants for the ribbon vertex expander.
package rve_pkg;

    localparam int COORD_BITS     = 32;
    localparam int TAN_BITS       = COORD_BITS + 1;
    localparam int WIDTH_BITS     = COORD_BITS - 1;
    localparam int COLOUR_BITS    = 32;
    localparam int SHRINK_BITS    = 30;
    localparam int MUL_BITS       = SHRINK_BITS + 2;
    localparam int PROD_BITS      = 2 * MUL_BITS;
    localparam int CROSS_BITS     = 2 * SHRINK_BITS + 1;
    localparam int SUM_BITS       = 2 * SHRINK_BITS + 2;
    localparam int ROOT_BITS      = SHRINK_BITS + 1;
    localparam int IN_FIELD_BITS  = 4 * COORD_BITS + WIDTH_BITS + COLOUR_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 4 * COORD_BITS + COLOUR_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_BITS-1:0] REG_EYE_X = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EYE_Y = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EYE_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } eye_t;

    // One element ready for expansion: position, tangent and attributes.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic signed [TAN_BITS-1:0]   tan_x;
        logic signed [TAN_BITS-1:0]   tan_y;
        logic signed [TAN_BITS-1:0]   tan_z;
        logic [WIDTH_BITS-1:0]        half_width;
        logic signed [COORD_BITS-1:0] tex_u;
        logic [COLOUR_BITS-1:0]       colour;
        logic                         last;
    } job_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

endpackage

// ===== rtl/ribbon_vertex_expander_unit.sv =====
// Top level of the ribbon vertex expander: eye registers, front end, queue and back end.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid / s_tready  s_tdata (element), s_tlast (last_element)
//  m_       out  m_tvalid / m_tready  m_tdata (vertex), m_tuser (vert_v), m_tlast (last_vertex)
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (eye_x, eye_y, eye_z)
//
// An element passes through the back end's shrink shifts, the bit-serial square root
// (31 steps) and three divide and scale passes sharing one 32x32 multiplier; a zero
// cross product skips the divides. The final element of a chain with a predecessor
// costs two back-end passes.
// Reset empties the window, the queue and the output register; no clearing pass.
// The front end accepts while the two-entry queue has room and no final job waits;
// a stalled output holds the back end in place.
module ribbon_vertex_expander_unit
    import rve_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // pos_x, pos_y, pos_z, half_width, tex_u,
                                                 // colour_rgba, zero fill
    input  logic                      s_tlast,   // last_element
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // vert_x, vert_y, vert_z, vert_colour, vert_u
    output logic                      m_tuser,   // vert_v
    output logic                      m_tlast,   // last_vertex
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data
);

    eye_t    eye_reg, eye_next;
    q_stat_t q_stat;
    job_t    push_job, q_head;
    logic    push, q_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        eye_next = eye_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_EYE_X: eye_next.x = cfg_data;
                REG_EYE_Y: eye_next.y = cfg_data;
                REG_EYE_Z: eye_next.z = cfg_data;
                default:   eye_next   = eye_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg <= '0;
        end
        else
        begin
            eye_reg <= eye_next;
        end
    end

    rve_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    rve_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    rve_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .eye      (eye_reg),
        .q_stat   (q_stat),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/rve_queue.sv =====
// Two-entry job queue between the element front end and the vertex back end.
module rve_queue
    import rve_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head,
    output q_stat_t stat
);

    job_t                   slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head           = slot_reg[rd_ptr_reg];
    assign stat.full      = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign stat.not_empty = (count_reg != '0);

endmodule

// ===== rtl/rve_front.sv =====
// Front end: accepts chain elements, keeps the window and queues expansion jobs.
module rve_front
    import rve_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_TDATA_BITS-1:0] s_tdata,   // pos_x, pos_y, pos_z, half_width, tex_u,
                                                // colour_rgba, zero fill
    input  logic                     s_tlast,   // last_element
    input  q_stat_t                  q_stat,
    output logic                     push,
    output job_t                     push_job
);

    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_ONE   = 2'd1;
    localparam logic [1:0] FILL_TWO   = 2'd2;

    localparam int X_LSB = 0;
    localparam int Y_LSB = COORD_BITS;
    localparam int Z_LSB = 2 * COORD_BITS;
    localparam int W_LSB = 3 * COORD_BITS;
    localparam int U_LSB = W_LSB + WIDTH_BITS;
    localparam int C_LSB = U_LSB + COORD_BITS;
    localparam int SB    = COORD_BITS - 1;

    logic signed [COORD_BITS-1:0] np_x, np_y, np_z, nu;
    logic [WIDTH_BITS-1:0]        nw;
    logic [COLOUR_BITS-1:0]       nc;
    logic                         accept;
    job_t                         held_job, end_job;

    logic signed [COORD_BITS-1:0] win0_x_reg, win0_y_reg, win0_z_reg;
    logic signed [COORD_BITS-1:0] win1_x_reg, win1_y_reg, win1_z_reg;
    logic [WIDTH_BITS-1:0]        held_width_reg;
    logic signed [COORD_BITS-1:0] held_u_reg;
    logic [COLOUR_BITS-1:0]       held_colour_reg;
    logic [1:0]                   fill_reg, fill_next;
    logic                         pend_valid_reg, pend_valid_next;
    job_t                         pend_reg;

    assign np_x = s_tdata[X_LSB +: COORD_BITS];
    assign np_y = s_tdata[Y_LSB +: COORD_BITS];
    assign np_z = s_tdata[Z_LSB +: COORD_BITS];
    assign nw   = s_tdata[W_LSB +: WIDTH_BITS];
    assign nu   = s_tdata[U_LSB +: COORD_BITS];
    assign nc   = s_tdata[C_LSB +: COLOUR_BITS];

    assign s_tready = !pend_valid_reg && !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        held_job.pos_x      = win1_x_reg;
        held_job.pos_y      = win1_y_reg;
        held_job.pos_z      = win1_z_reg;
        // one-sided difference while the held element opens the chain
        if (fill_reg == FILL_ONE)
        begin
            held_job.tan_x = $signed({np_x[SB], np_x}) - $signed({win1_x_reg[SB], win1_x_reg});
            held_job.tan_y = $signed({np_y[SB], np_y}) - $signed({win1_y_reg[SB], win1_y_reg});
            held_job.tan_z = $signed({np_z[SB], np_z}) - $signed({win1_z_reg[SB], win1_z_reg});
        end
        else
        begin
            held_job.tan_x = $signed({np_x[SB], np_x}) - $signed({win0_x_reg[SB], win0_x_reg});
            held_job.tan_y = $signed({np_y[SB], np_y}) - $signed({win0_y_reg[SB], win0_y_reg});
            held_job.tan_z = $signed({np_z[SB], np_z}) - $signed({win0_z_reg[SB], win0_z_reg});
        end
        held_job.half_width = held_width_reg;
        held_job.tex_u      = held_u_reg;
        held_job.colour     = held_colour_reg;
        held_job.last       = 1'b0;

        end_job.pos_x      = np_x;
        end_job.pos_y      = np_y;
        end_job.pos_z      = np_z;
        end_job.tan_x      = $signed({np_x[SB], np_x}) - $signed({win1_x_reg[SB], win1_x_reg});
        end_job.tan_y      = $signed({np_y[SB], np_y}) - $signed({win1_y_reg[SB], win1_y_reg});
        end_job.tan_z      = $signed({np_z[SB], np_z}) - $signed({win1_z_reg[SB], win1_z_reg});
        end_job.half_width = nw;
        end_job.tex_u      = nu;
        end_job.colour     = nc;
        end_job.last       = 1'b1;
    end

    always_comb
    begin
        fill_next       = fill_reg;
        pend_valid_next = pend_valid_reg;
        push            = 1'b0;
        push_job        = held_job;
        if (pend_valid_reg)
        begin
            // drain the chain's final job before taking a new transaction
            push_job = pend_reg;
            if (!q_stat.full)
            begin
                push            = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (fill_reg == FILL_EMPTY)
            begin
                fill_next = s_tlast ? FILL_EMPTY : FILL_ONE;
            end
            else
            begin
                push            = 1'b1;
                pend_valid_next = s_tlast;
                fill_next       = s_tlast ? FILL_EMPTY : FILL_TWO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= FILL_EMPTY;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !s_tlast)
        begin
            win0_x_reg      <= win1_x_reg;
            win0_y_reg      <= win1_y_reg;
            win0_z_reg      <= win1_z_reg;
            win1_x_reg      <= np_x;
            win1_y_reg      <= np_y;
            win1_z_reg      <= np_z;
            held_width_reg  <= nw;
            held_u_reg      <= nu;
            held_colour_reg <= nc;
        end
        if (accept && s_tlast)
        begin
            pend_reg <= end_job;
        end
    end

endmodule

// ===== rtl/rve_back.sv =====
// Back end: computes the ribbon offset of one job and emits its two vertices.
`include "ribbon_vertex_expander_unit_assert.svh"

module rve_back
    import rve_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  eye_t                      eye,
    input  q_stat_t                   q_stat,
    input  job_t                      q_head,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,  // vert_x, vert_y, vert_z, vert_colour, vert_u
    output logic                      m_tuser,  // vert_v
    output logic                      m_tlast   // last_vertex
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_SHTE  = 12'b0000_0000_0010,
        ST_CROSS = 12'b0000_0000_0100,
        ST_SHC   = 12'b0000_0000_1000,
        ST_SQ    = 12'b0000_0001_0000,
        ST_ROOT  = 12'b0000_0010_0000,
        ST_DLOAD = 12'b0000_0100_0000,
        ST_DIV   = 12'b0000_1000_0000,
        ST_SCL   = 12'b0001_0000_0000,
        ST_OFF   = 12'b0010_0000_0000,
        ST_V0    = 12'b0100_0000_0000,
        ST_V1    = 12'b1000_0000_0000
    } state_t;

    state_t                      state_reg, state_next;
    job_t                        job_reg, job_next;
    logic [TAN_BITS-1:0]         t_mag_reg [3], t_mag_next [3];
    logic [TAN_BITS-1:0]         e_mag_reg [3], e_mag_next [3];
    logic [2:0]                  t_neg_reg, t_neg_next;
    logic [2:0]                  e_neg_reg, e_neg_next;
    logic [CROSS_BITS-1:0]       c_mag_reg [3], c_mag_next [3];
    logic [2:0]                  c_neg_reg, c_neg_next;
    logic signed [SUM_BITS-1:0]  first_reg, first_next;
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]         sum_reg, sum_next;
    logic [SUM_BITS-1:0]         root_reg, root_next;
    logic [SUM_BITS-2:0]         bit_reg, bit_next;
    logic [ROOT_BITS-1:0]        len_reg, len_next;
    logic [ROOT_BITS:0]          rem_reg, rem_next;
    logic [ROOT_BITS-1:0]        quo_reg, quo_next;
    logic [1:0]                  comp_reg, comp_next;
    logic [ROOT_BITS-1:0]        off_reg [3], off_next [3];
    logic                        out_valid_reg, out_valid_next;
    logic [OUT_TDATA_BITS-1:0]   out_data_reg, out_data_next;
    logic                        out_user_reg, out_user_next;
    logic                        out_last_reg, out_last_next;

    logic signed [MUL_BITS-1:0]  mul_a, mul_b;
    logic signed [PROD_BITS-1:0] mul_p;
    logic                        out_free;
    logic                        c_hi_clear;

    function automatic logic [TAN_BITS-1:0] mag_of(input logic signed [TAN_BITS-1:0] v);
        return v[TAN_BITS-1] ? TAN_BITS'(-v) : TAN_BITS'(v);
    endfunction

    function automatic logic signed [MUL_BITS-1:0] signed_of(
        input logic [SHRINK_BITS-1:0] m, input logic neg);
        logic signed [MUL_BITS-1:0] v;
        v = $signed({2'b00, m});
        return neg ? -v : v;
    endfunction

    // Position plus or minus the offset magnitude, saturated.
    function automatic logic [COORD_BITS-1:0] vertex_of(
        input logic signed [COORD_BITS-1:0] p, input logic [ROOT_BITS-1:0] m,
        input logic add);
        logic signed [COORD_BITS+1:0] pe, oe, s;
        pe = $signed({{2{p[COORD_BITS-1]}}, p});
        oe = $signed({3'b000, m});
        s  = add ? pe + oe : pe - oe;
        if (s[COORD_BITS+1:COORD_BITS-1] == 3'b000 || s[COORD_BITS+1:COORD_BITS-1] == 3'b111)
        begin
            return s[COORD_BITS-1:0];
        end
        return s[COORD_BITS+1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                               : {1'b0, {(COORD_BITS-1){1'b1}}};
    endfunction

    assign mul_p      = mul_a * mul_b;
    assign out_free   = !out_valid_reg || m_tready;
    assign c_hi_clear = (c_mag_reg[0][CROSS_BITS-1:SHRINK_BITS] == '0)
                     && (c_mag_reg[1][CROSS_BITS-1:SHRINK_BITS] == '0)
                     && (c_mag_reg[2][CROSS_BITS-1:SHRINK_BITS] == '0);

    always_comb
    begin
        logic signed [TAN_BITS-1:0] tv [3];
        logic signed [TAN_BITS-1:0] ev [3];
        logic                       t_big, e_big, c_big;
        logic [2:0]                 jj;
        logic signed [SUM_BITS-1:0] diff;
        logic [SUM_BITS-1:0]        trial;
        logic [SUM_BITS-1:0]        root_step;
        logic                       ge;
        logic [ROOT_BITS:0]         rs;
        logic                       side;

        state_next     = state_reg;
        job_next       = job_reg;
        t_mag_next     = t_mag_reg;
        e_mag_next     = e_mag_reg;
        t_neg_next     = t_neg_reg;
        e_neg_next     = e_neg_reg;
        c_mag_next     = c_mag_reg;
        c_neg_next     = c_neg_reg;
        first_next     = first_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        comp_next      = comp_reg;
        off_next       = off_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        tv[0] = q_head.tan_x;
        tv[1] = q_head.tan_y;
        tv[2] = q_head.tan_z;
        ev[0] = $signed({eye.x[COORD_BITS-1], eye.x})
              - $signed({q_head.pos_x[COORD_BITS-1], q_head.pos_x});
        ev[1] = $signed({eye.y[COORD_BITS-1], eye.y})
              - $signed({q_head.pos_y[COORD_BITS-1], q_head.pos_y});
        ev[2] = $signed({eye.z[COORD_BITS-1], eye.z})
              - $signed({q_head.pos_z[COORD_BITS-1], q_head.pos_z});
        t_big = (|t_mag_reg[0][TAN_BITS-1:SHRINK_BITS]) || (|t_mag_reg[1][TAN_BITS-1:SHRINK_BITS])
             || (|t_mag_reg[2][TAN_BITS-1:SHRINK_BITS]);
        e_big = (|e_mag_reg[0][TAN_BITS-1:SHRINK_BITS]) || (|e_mag_reg[1][TAN_BITS-1:SHRINK_BITS])
             || (|e_mag_reg[2][TAN_BITS-1:SHRINK_BITS]);
        c_big = !c_hi_clear;
        jj        = cnt_reg[2:0] - 3'd1;
        diff      = first_reg - prod_reg[SUM_BITS-1:0];
        trial     = root_reg + {1'b0, bit_reg};
        root_step = (sum_reg >= trial) ? (root_reg >> 1) + {1'b0, bit_reg} : root_reg >> 1;
        ge        = rem_reg >= {1'b0, len_reg};
        rs        = ge ? rem_reg - {1'b0, len_reg} : rem_reg;
        side      = (state_reg == ST_V1);

        case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.not_empty)
                begin
                    q_pop    = 1'b1;
                    job_next = q_head;
                    for (int k = 0; k < 3; k++)
                    begin
                        t_mag_next[k] = mag_of(tv[k]);
                        t_neg_next[k] = tv[k][TAN_BITS-1];
                        e_mag_next[k] = mag_of(ev[k]);
                        e_neg_next[k] = ev[k][TAN_BITS-1];
                    end
                    state_next = ST_SHTE;
                end
            end
            ST_SHTE:
            begin
                // shift each vector as a whole until all magnitudes fit
                for (int k = 0; k < 3; k++)
                begin
                    if (t_big)
                    begin
                        t_mag_next[k] = t_mag_reg[k] >> 1;
                    end
                    if (e_big)
                    begin
                        e_mag_next[k] = e_mag_reg[k] >> 1;
                    end
                end
                if (!t_big && !e_big)
                begin
                    cnt_next   = '0;
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS:
            begin
                // issue product cnt, fold in product cnt-1
                case (cnt_reg[2:0])
                    3'd0:
                    begin
                        mul_a = signed_of(t_mag_reg[1][SHRINK_BITS-1:0], t_neg_reg[1]);
                        mul_b = signed_of(e_mag_reg[2][SHRINK_BITS-1:0], e_neg_reg[2]);
                    end
                    3'd1:
                    begin
                        mul_a = signed_of(t_mag_reg[2][SHRINK_BITS-1:0], t_neg_reg[2]);
                        mul_b = signed_of(e_mag_reg[1][SHRINK_BITS-1:0], e_neg_reg[1]);
                    end
                    3'd2:
                    begin
                        mul_a = signed_of(t_mag_reg[2][SHRINK_BITS-1:0], t_neg_reg[2]);
                        mul_b = signed_of(e_mag_reg[0][SHRINK_BITS-1:0], e_neg_reg[0]);
                    end
                    3'd3:
                    begin
                        mul_a = signed_of(t_mag_reg[0][SHRINK_BITS-1:0], t_neg_reg[0]);
                        mul_b = signed_of(e_mag_reg[2][SHRINK_BITS-1:0], e_neg_reg[2]);
                    end
                    3'd4:
                    begin
                        mul_a = signed_of(t_mag_reg[0][SHRINK_BITS-1:0], t_neg_reg[0]);
                        mul_b = signed_of(e_mag_reg[1][SHRINK_BITS-1:0], e_neg_reg[1]);
                    end
                    3'd5:
                    begin
                        mul_a = signed_of(t_mag_reg[1][SHRINK_BITS-1:0], t_neg_reg[1]);
                        mul_b = signed_of(e_mag_reg[0][SHRINK_BITS-1:0], e_neg_reg[0]);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
                prod_next = mul_p;
                if (cnt_reg != '0)
                begin
                    if (!jj[0])
                    begin
                        first_next = prod_reg[SUM_BITS-1:0];
                    end
                    else
                    begin
                        c_neg_next[jj[2:1]] = diff[SUM_BITS-1];
                        c_mag_next[jj[2:1]] = diff[SUM_BITS-1] ? CROSS_BITS'(-diff)
                                                                : CROSS_BITS'(diff);
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd6)
                begin
                    cnt_next   = '0;
                    state_next = ST_SHC;
                end
            end
            ST_SHC:
            begin
                if (c_big)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        c_mag_next[k] = c_mag_reg[k] >> 1;
                    end
                end
                else
                begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (cnt_reg[1:0] != 2'd3)
                begin
                    mul_a = signed_of(c_mag_reg[cnt_reg[1:0]][SHRINK_BITS-1:0], 1'b0);
                    mul_b = mul_a;
                end
                prod_next = mul_p;
                if (cnt_reg != '0)
                begin
                    sum_next = sum_reg + prod_reg[SUM_BITS-1:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd3)
                begin
                    root_next  = '0;
                    bit_next   = {1'b1, {(SUM_BITS-2){1'b0}}};
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                // one result bit per cycle
                if (sum_reg >= trial)
                begin
                    sum_next = sum_reg - trial;
                end
                root_next = root_step;
                bit_next  = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    len_next  = root_step[ROOT_BITS-1:0];
                    comp_next = '0;
                    if (root_step == '0)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            off_next[k] = '0;
                        end
                        state_next = ST_V0;
                    end
                    else
                    begin
                        state_next = ST_DLOAD;
                    end
                end
            end
            ST_DLOAD:
            begin
                rem_next   = {2'b00, c_mag_reg[comp_reg][SHRINK_BITS-1:0]};
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                quo_next = {quo_reg[ROOT_BITS-2:0], ge};
                rem_next = {rs[ROOT_BITS-1:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(ROOT_BITS - 1))
                begin
                    state_next = ST_SCL;
                end
            end
            ST_SCL:
            begin
                mul_a      = $signed({1'b0, quo_reg});
                mul_b      = $signed({1'b0, job_reg.half_width});
                prod_next  = mul_p;
                state_next = ST_OFF;
            end
            ST_OFF:
            begin
                off_next[comp_reg] = prod_reg[ROOT_BITS+SHRINK_BITS-1:SHRINK_BITS];
                if (comp_reg == 2'd2)
                begin
                    state_next = ST_V0;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_DLOAD;
                end
            end
            ST_V0, ST_V1:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {job_reg.tex_u, job_reg.colour,
                        vertex_of(job_reg.pos_z, off_reg[2], side ^ c_neg_reg[2]),
                        vertex_of(job_reg.pos_y, off_reg[1], side ^ c_neg_reg[1]),
                        vertex_of(job_reg.pos_x, off_reg[0], side ^ c_neg_reg[0])};
                    out_user_next  = side;
                    out_last_next  = side && job_reg.last;
                    state_next     = side ? ST_IDLE : ST_V1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        t_mag_reg    <= t_mag_next;
        e_mag_reg    <= e_mag_next;
        t_neg_reg    <= t_neg_next;
        e_neg_reg    <= e_neg_next;
        c_mag_reg    <= c_mag_next;
        c_neg_reg    <= c_neg_next;
        first_reg    <= first_next;
        prod_reg     <= prod_next;
        sum_reg      <= sum_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        off_reg      <= off_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    `RVE_ASSERT_NOW(a_div_len_nonzero, state_reg == ST_DIV, len_reg != '0,
        "divider started with a zero length")
    `RVE_ASSERT_NOW(a_cross_shrunk, state_reg == ST_SQ, c_hi_clear,
        "cross product not shrunk before squaring")
    `RVE_ASSERT_NEXT(a_plus_follows, state_reg == ST_V0 && out_free,
        state_reg == ST_V1 && m_tvalid && !m_tuser,
        "minus vertex not followed by plus vertex")

endmodule

// ===== tb/ribbon_vertex_expander_unit_tb.sv =====
// Self-checking testbench for the ribbon vertex expander: predicted ribbon vertices vs the stream.
module ribbon_vertex_expander_unit_tb;
    import rve_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  DRAIN_CYCLES = 450;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef longint vec3_t [3];

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        half_width;
        logic signed [31:0] tex_u;
        logic [31:0]        colour;
        logic               last;
    } element_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] colour;
        logic [31:0] u;
        logic        v;
        logic        last;
    } vertex_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata;
    logic                      s_tlast;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [COORD_BITS-1:0]     cfg_data;

    element_t pending_elements[$];
    vertex_t  expected_vertices[$];
    bit       element_in_flight;
    bit       no_idle;
    bit       failed;
    int       cycle_count;

    // predictor state
    longint          eye[3];
    longint          win_prev[3];
    longint          win_held[3];
    longint unsigned held_width;
    logic [31:0]     held_u;
    logic [31:0]     held_colour;
    int              fill_count;

    logic signed [31:0] cursor[3];

    ribbon_vertex_expander_unit u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint unsigned magnitude(longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    // Scale all components down together until each magnitude is below 2^30.
    function automatic vec3_t shrink_vec(vec3_t a);
        longint unsigned m;
        int              s;
        vec3_t           r;
        m = 0;
        s = 0;
        for (int k = 0; k < 3; k++)
            if (magnitude(a[k]) > m) m = magnitude(a[k]);
        while ((m >> s) >= (64'd1 << 30)) s++;
        for (int k = 0; k < 3; k++)
        begin
            r[k] = longint'(magnitude(a[k]) >> s);
            if (a[k] < 0) r[k] = -r[k];
        end
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] saturate(longint a);
        if (a > SMAX) return 32'h7fff_ffff;
        if (a < SMIN) return 32'h8000_0000;
        return a[31:0];
    endfunction

    // Queue the minus and plus vertices of one element.
    task automatic expect_vertex_pair(vec3_t p, vec3_t tangent, longint unsigned w,
                                      logic [31:0] u, logic [31:0] colour, bit last);
        vec3_t           t;
        vec3_t           e;
        vec3_t           c;
        vec3_t           off;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned unit;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned r;
        vertex_t         vx;
        for (int k = 0; k < 3; k++)
        begin
            e[k] = eye[k] - p[k];
            off[k] = 0;
        end
        t = shrink_vec(tangent);
        e = shrink_vec(e);
        c[0] = t[1] * e[2] - t[2] * e[1];
        c[1] = t[2] * e[0] - t[0] * e[2];
        c[2] = t[0] * e[1] - t[1] * e[0];
        c = shrink_vec(c);
        sum = 0;
        for (int k = 0; k < 3; k++) sum += magnitude(c[k]) * magnitude(c[k]);
        len = int_sqrt(sum);
        if (len != 0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                unit = (magnitude(c[k]) << 30) / len;
                hi = unit * (w >> 16);
                lo = unit * (w & 64'hFFFF);
                r = (hi >> 14) + ((((hi & 64'h3FFF) << 16) + lo) >> 30);
                off[k] = (c[k] < 0) ? -longint'(r) : longint'(r);
            end
        end
        for (int side = 0; side < 2; side++)
        begin
            vx.x = saturate(side ? p[0] + off[0] : p[0] - off[0]);
            vx.y = saturate(side ? p[1] + off[1] : p[1] - off[1]);
            vx.z = saturate(side ? p[2] + off[2] : p[2] - off[2]);
            vx.colour = colour;
            vx.u = u;
            vx.v = side[0];
            vx.last = last && (side == 1);
            expected_vertices.push_back(vx);
        end
    endtask

    task automatic predict_element(element_t el);
        vec3_t np;
        vec3_t hp;
        vec3_t t;
        np[0] = el.pos_x;
        np[1] = el.pos_y;
        np[2] = el.pos_z;
        if (fill_count == 0)
        begin
            if (!el.last)
            begin
                win_held = np;
                held_width = el.half_width;
                held_u = el.tex_u;
                held_colour = el.colour;
                fill_count = 1;
            end
            return;
        end
        hp = win_held;
        for (int k = 0; k < 3; k++)
            t[k] = (fill_count == 1) ? np[k] - hp[k] : np[k] - win_prev[k];
        expect_vertex_pair(hp, t, held_width, held_u, held_colour, 1'b0);
        if (el.last)
        begin
            for (int k = 0; k < 3; k++) t[k] = np[k] - hp[k];
            expect_vertex_pair(np, t, el.half_width, el.tex_u, el.colour, 1'b1);
            fill_count = 0;
        end
        else
        begin
            win_prev = hp;
            win_held = np;
            held_width = el.half_width;
            held_u = el.tex_u;
            held_colour = el.colour;
            fill_count = 2;
        end
    endtask

    // element driver
    always @(negedge clk)
    begin
        if (rst_n && !element_in_flight)
        begin
            if (pending_elements.size() > 0 && (no_idle || $urandom_range(99) >= 36))
            begin
                s_tdata <= {1'b0, pending_elements[0].colour, pending_elements[0].tex_u,
                            pending_elements[0].half_width, pending_elements[0].pos_z,
                            pending_elements[0].pos_y, pending_elements[0].pos_x};
                s_tlast <= pending_elements[0].last;
                s_tvalid <= 1'b1;
                element_in_flight = 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready && element_in_flight)
        begin
            predict_element(pending_elements.pop_front());
            element_in_flight = 1'b0;
        end
    end

    // vertex receiver
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= no_idle || $urandom_range(99) >= 36;
    end

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_vertices.size() == 0)
            begin
                $display("%0t: unexpected vertex, expected none, actual %h", $time, m_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = expected_vertices.pop_front();
                check_field("vert_x", m_tdata[31:0], want.x);
                check_field("vert_y", m_tdata[63:32], want.y);
                check_field("vert_z", m_tdata[95:64], want.z);
                check_field("vert_colour", m_tdata[127:96], want.colour);
                check_field("vert_u", m_tdata[159:128], want.u);
                check_field("vert_v", {31'd0, m_tuser}, {31'd0, want.v});
                check_field("last_vertex", {31'd0, m_tlast}, {31'd0, want.last});
            end
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_EYE_X: eye[0] = longint'(signed'(value));
            REG_EYE_Y: eye[1] = longint'(signed'(value));
            REG_EYE_Z: eye[2] = longint'(signed'(value));
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_eye(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
        write_reg(REG_EYE_X, ex);
        write_reg(REG_EYE_Y, ey);
        write_reg(REG_EYE_Z, ez);
    endtask

    task automatic add_element(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [30:0] w, logic [31:0] u, logic [31:0] c, bit last);
        element_t el;
        el.pos_x = x;
        el.pos_y = y;
        el.pos_z = z;
        el.half_width = w;
        el.tex_u = u;
        el.colour = c;
        el.last = last;
        pending_elements.push_back(el);
    endtask

    // Hold until every result has arrived, then let the back end settle.
    task automatic wait_drained();
        while (pending_elements.size() > 0 || element_in_flight || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int k);
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return cursor[k];
            default: return cursor[k] + $signed($urandom_range(2 << 20)) - (1 << 20);
        endcase
    endfunction

    function automatic logic [30:0] rand_width();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return 31'd0;
            1: return 31'h7fff_ffff;
            2, 3: return r[30:0];
            default: return 31'($urandom_range(32'h0010_0000));
        endcase
    endfunction

    task automatic add_random_chains(int count);
        int len;
        int added;
        added = 0;
        while (added < count)
        begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 7);
            for (int i = 0; i < len; i++)
            begin
                for (int k = 0; k < 3; k++) cursor[k] = rand_coord(k);
                add_element(cursor[0], cursor[1], cursor[2], rand_width(), $urandom, $urandom,
                            i == len - 1);
                added++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_EYE_X;
        cfg_data = '0;
        element_in_flight = 1'b0;
        no_idle = 1'b0;
        failed = 1'b0;
        cycle_count = 0;
        eye = '{0, 0, 0};
        win_prev = '{0, 0, 0};
        win_held = '{0, 0, 0};
        held_width = 0;
        held_u = '0;
        held_colour = '0;
        fill_count = 0;
        cursor = '{0, 0, 0};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-element chain: no output
        add_element(32'h0001_0000, 32'h0002_0000, 0, 31'h0001_0000, 32'h0000_8000, 0, 1'b1);
        // two-element chain, eye at origin
        add_element(32'h0001_0000, 0, 0, 31'h0000_8000, 0, 32'h1122_3344, 1'b0);
        add_element(32'h0001_0000, 32'h0001_0000, 0, 31'h0001_0000, 32'h0001_0000,
                    32'h5566_7788, 1'b1);
        // eye on the tangent line
        add_element(32'h0001_0000, 0, 0, 31'h0001_0000, 0, 32'hffff_ffff, 1'b0);
        add_element(32'h0002_0000, 0, 0, 31'h0001_0000, 0, 32'hffff_ffff, 1'b0);
        add_element(32'h0003_0000, 0, 0, 31'h0001_0000, 0, 32'hffff_ffff, 1'b1);
        // coincident points
        add_element(32'h0004_0000, 32'h0005_0000, 32'hfffa_0000, 31'h0002_0000, 7, 1, 1'b0);
        add_element(32'h0004_0000, 32'h0005_0000, 32'hfffa_0000, 31'h0002_0000, 7, 1, 1'b1);
        // extremes with saturation
        add_element(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000,
                    32'hffff_ffff, 1'b0);
        add_element(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff,
                    0, 1'b0);
        add_element(32'h7fff_ffff, 32'h8000_0000, 0, 31'h7fff_ffff, 32'hffff_ffff,
                    32'haaaa_5555, 1'b1);
        // zero width
        add_element(0, 32'h0001_0000, 32'h0003_0000, 31'd0, 1, 2, 1'b0);
        add_element(32'h0002_0000, 32'h0001_0000, 32'h0004_0000, 31'd0, 3, 4, 1'b0);
        add_element(32'h0003_0000, 32'h0005_0000, 32'h0001_0000, 31'd0, 5, 6, 1'b1);
        wait_drained();

        set_eye(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        write_reg(REG_UNUSED, 32'hdead_beef);
        add_random_chains(60);
        wait_drained();

        set_eye(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        no_idle = 1'b1;
        add_random_chains(60);
        wait_drained();
        no_idle = 1'b0;

        set_eye($urandom, $urandom, $urandom);
        add_random_chains(60);
        wait_drained();

        set_eye(32'h0000_8000, 32'hfffe_0000, 32'h0003_0000);
        add_random_chains(70);
        wait_drained();

        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rve_pkg.sv
rtl/rve_queue.sv
rtl/rve_front.sv
rtl/rve_back.sv
rtl/ribbon_vertex_expander_unit.sv
tb/ribbon_vertex_expander_unit_tb.sv
